// File: design/cbsmd_pkg.sv
// ----------------------------------------------------------------------------
// cbsmd_pkg
// Types and constants shared by the cyclic band-shift distance block.
// ----------------------------------------------------------------------------
package cbsmd_pkg;

    localparam int MAX_LEN  = 256;
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int LEN_W    = ADDR_W + 1;
    localparam int PADDR_W  = 4;
    localparam int SCORE_W  = 48;
    localparam int SQ_W     = 32;
    localparam int BSQ_W    = SQ_W + LEN_W - 1;
    localparam int DIV_STEPS  = SCORE_W;
    localparam int SQRT_STEPS = SCORE_W / 2;

    localparam logic [SCORE_W-1:0] SCORE_INF = '1;

    localparam logic [1:0] REG_BAND_SIZE = 2'd0;
    localparam logic [1:0] REG_USE_CONF  = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd1;
    localparam logic [1:0] STATUS_NO_VALID = 2'd2;

    typedef struct packed {
        logic signed [15:0] a_value;
        logic signed [15:0] b_value;
        logic               last;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         best_shift;
        logic [SCORE_W-1:0] best_distance;
        logic [8:0]         valid_count;
    } t_out;

    typedef struct packed {
        logic [8:0]         band_size;
        logic               use_confidence;
        logic signed [15:0] invalid_threshold;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN,
        ST_DRAIN,
        ST_DIV,
        ST_CMP,
        ST_SQRT,
        ST_DONE
    } t_state;

endpackage

// File: design/cbsmd_mem.sv
// ----------------------------------------------------------------------------
// cbsmd_mem
// Element stores for both vectors: one write port, one read port each.
// ----------------------------------------------------------------------------
module cbsmd_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [cbsmd_pkg::ADDR_W-1:0] i_waddr,
    input  logic signed [15:0]          i_wref,
    input  logic signed [15:0]          i_wshf,
    input  logic [cbsmd_pkg::ADDR_W-1:0] i_raddr_ref,
    input  logic [cbsmd_pkg::ADDR_W-1:0] i_raddr_shf,
    output logic signed [15:0]          o_rref,
    output logic signed [15:0]          o_rshf
);
    import cbsmd_pkg::*;

    logic signed [15:0] r_ref_mem [MAX_LEN];
    logic signed [15:0] r_shf_mem [MAX_LEN];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_ref_mem[i_waddr] <= i_wref;
            r_shf_mem[i_waddr] <= i_wshf;
        end
        o_rref <= r_ref_mem[i_raddr_ref];
        o_rshf <= r_shf_mem[i_raddr_shf];
    end

endmodule

// File: design/cbsmd_apb.sv
// ----------------------------------------------------------------------------
// cbsmd_apb
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module cbsmd_apb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbsmd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output cbsmd_pkg::t_cfg               o_cfg
);
    import cbsmd_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band_size         <= 9'd4;
            r_cfg.use_confidence    <= 1'b0;
            r_cfg.invalid_threshold <= 16'sd12868;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_BAND_SIZE: r_cfg.band_size         <= pwdata[8:0];
                REG_USE_CONF:  r_cfg.use_confidence    <= pwdata[0];
                REG_THRESHOLD: r_cfg.invalid_threshold <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BAND_SIZE: prdata = {23'd0, r_cfg.band_size};
            REG_USE_CONF:  prdata = {31'd0, r_cfg.use_confidence};
            REG_THRESHOLD: prdata = {16'd0, r_cfg.invalid_threshold};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

// File: design/cyclic_band_shift_min_distance.sv
// ----------------------------------------------------------------------------
// cyclic_band_shift_min_distance
// Loads two vectors into element stores, then scores every cyclic band shift
// with a read-square-accumulate pipeline and reports the first minimum.
// ----------------------------------------------------------------------------
//  channel   ports                              handshake
//  request   i_req (a_value, b_value, last)     start && !busy
//  result    o_res (status, shift, dist, vc)    o_done, one cycle
//  config    psel penable pwrite paddr pwdata   psel && penable && pwrite
//
//  A request without last only stores its element pair. A request with last
//  stores its pair and starts a search: the check state tests the band size,
//  then per shift the run state reads the stores, the drain state empties the
//  pipeline, the divider runs in confidence mode when the shift has valid
//  data, and the compare state keeps the better score; the square root
//  follows in plain mode, then the done state forms the result, which shows
//  on the cycle after. The store read port sets the per-element pace. Reset
//  clears the load count and control; the stores need no clearing. The
//  receiver cannot stall, so a result is shown once for one cycle.
// ----------------------------------------------------------------------------
module cyclic_band_shift_min_distance (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  cbsmd_pkg::t_in                i_req,
    output logic                          o_done,
    output cbsmd_pkg::t_out               o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbsmd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import cbsmd_pkg::*;

    t_cfg   cfg;
    t_state r_state, n_state;

    logic               accept;
    logic [LEN_W-1:0]   r_loaded, r_len, len_new;
    logic [LEN_W-1:0]   r_rem, r_shifts, bs_m1;
    logic               r_err;
    logic [ADDR_W-1:0]  r_j, r_idx, r_base, r_s, r_bpos;
    logic [LEN_W-1:0]   base_nxt;
    logic               last_elem, last_shift, pipe_empty, bad_cfg;

    logic signed [15:0] rd_ref, rd_shf;
    logic               r_p0, r_p0_bend;
    logic               r_p1, r_p1_bend, r_p1_ok;
    logic signed [16:0] r_p1_d;
    logic signed [33:0] sq_full;
    logic               r_p2, r_p2_bend, r_p2_ok;
    logic [SQ_W-1:0]    r_p2_sq;
    logic [BSQ_W-1:0]   r_bsq, bsq_sum, r_p3_sq, r_tsq;
    logic [LEN_W-1:0]   r_bcnt, bcnt_sum, r_p3_cnt, r_tv;
    logic               r_p3;
    logic [BSQ_W+LEN_W-1:0] band_prod;
    logic [SCORE_W-1:0] r_num;

    logic [SCORE_W-1:0] r_score, r_best, r_work;
    logic [ADDR_W-1:0]  r_best_idx;
    logic [LEN_W-1:0]   r_best_vc;
    logic [5:0]         r_cnt;
    logic [LEN_W-1:0]   r_drem;
    logic [LEN_W:0]     div_t;
    logic               div_ge;
    logic [SCORE_W-1:0] quo_nxt;
    logic [SQRT_STEPS:0] r_srem;
    logic [SQRT_STEPS-1:0] r_root;
    logic [SQRT_STEPS+2:0] sq_t, sq_trial;
    logic               sq_ge;
    logic               better;

    cbsmd_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cbsmd_mem u_mem (
        .i_clk       (i_clk),
        .i_we        (accept && (r_loaded < LEN_W'(MAX_LEN))),
        .i_waddr     (r_loaded[ADDR_W-1:0]),
        .i_wref      (i_req.a_value),
        .i_wshf      (i_req.b_value),
        .i_raddr_ref (r_j),
        .i_raddr_shf (r_idx),
        .o_rref      (rd_ref),
        .o_rshf      (rd_shf)
    );

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign len_new = (r_loaded < LEN_W'(MAX_LEN)) ? r_loaded + 1'b1 : r_loaded;
    assign bs_m1   = cfg.band_size - 1'b1;
    assign bad_cfg = (cfg.band_size == '0) || (r_len == '0);
    assign last_elem  = ({1'b0, r_j} == r_len - 1'b1);
    assign last_shift = ({1'b0, r_s} + 1'b1 == r_shifts);
    assign base_nxt   = {1'b0, r_base} + cfg.band_size;
    assign pipe_empty = !r_p0 && !r_p1 && !r_p2 && !r_p3;

    assign sq_full   = r_p1_d * r_p1_d;
    assign bsq_sum   = r_bsq + BSQ_W'(r_p2_sq);
    assign bcnt_sum  = r_bcnt + LEN_W'(r_p2_ok);
    assign band_prod = r_p3_sq * r_p3_cnt;

    // one restoring divider step
    assign div_t   = {r_drem, r_work[SCORE_W-1]};
    assign div_ge  = (div_t >= {1'b0, r_tv});
    assign quo_nxt = {r_work[SCORE_W-2:0], div_ge};

    // one square root digit
    assign sq_t     = {r_srem, r_work[SCORE_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = (sq_t >= sq_trial);

    assign better = (r_score < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_req.last) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (bad_cfg) begin
                    n_state = ST_DONE;
                end else if (r_rem < cfg.band_size) begin
                    n_state = (r_rem != '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_elem) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    n_state = (cfg.use_confidence && (r_tv != '0)) ? ST_DIV : ST_CMP;
                end
            end
            ST_DIV: begin
                if (r_cnt == 6'(DIV_STEPS - 1)) n_state = ST_CMP;
            end
            ST_CMP: begin
                if (!last_shift) n_state = ST_RUN;
                else if (!cfg.use_confidence) n_state = ST_SQRT;
                else n_state = ST_DONE;
            end
            ST_SQRT: begin
                if (r_cnt == 6'(SQRT_STEPS - 1)) n_state = ST_DONE;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_err    <= 1'b0;
            r_p0     <= 1'b0;
            r_p1     <= 1'b0;
            r_p2     <= 1'b0;
            r_p3     <= 1'b0;
            o_done   <= 1'b0;
        end else begin
            o_done <= (r_state == ST_DONE);
            r_p0   <= (r_state == ST_RUN);
            r_p1   <= r_p0;
            r_p2   <= r_p1;
            r_p3   <= r_p2 && r_p2_bend;
            if (accept) begin
                r_loaded <= i_req.last ? '0 : len_new;
                r_err    <= 1'b0;
            end
            if (r_state == ST_CHECK) begin
                if (bad_cfg || ((r_rem < cfg.band_size) && (r_rem != '0))) r_err <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept && i_req.last) r_len <= len_new;

        r_p0_bend <= ({1'b0, r_bpos} == bs_m1);
        r_p1_bend <= r_p0_bend;
        r_p1_d    <= 17'(rd_ref) - 17'(rd_shf);
        r_p1_ok   <= !cfg.use_confidence ||
                     ((rd_ref <= cfg.invalid_threshold) && (rd_shf <= cfg.invalid_threshold));
        r_p2_bend <= r_p1_bend;
        r_p2_ok   <= r_p1_ok;
        r_p2_sq   <= r_p1_ok ? sq_full[SQ_W-1:0] : '0;

        if (r_p2) begin
            r_tsq <= r_tsq + BSQ_W'(r_p2_sq);
            r_tv  <= r_tv + LEN_W'(r_p2_ok);
            if (r_p2_bend) begin
                r_p3_sq  <= bsq_sum;
                r_p3_cnt <= bcnt_sum;
                r_bsq    <= '0;
                r_bcnt   <= '0;
            end else begin
                r_bsq  <= bsq_sum;
                r_bcnt <= bcnt_sum;
            end
        end
        if (r_p3) r_num <= r_num + band_prod[SCORE_W-1:0];

        case (r_state)
            ST_IDLE: begin
                r_rem    <= len_new;
                r_shifts <= '0;
            end
            ST_CHECK: begin
                if (r_rem >= cfg.band_size) begin
                    r_rem    <= r_rem - cfg.band_size;
                    r_shifts <= r_shifts + 1'b1;
                end
                r_best     <= SCORE_INF;
                r_best_idx <= '0;
                r_best_vc  <= '0;
                r_s        <= '0;
                r_base     <= '0;
                r_j        <= '0;
                r_idx      <= '0;
                r_bpos     <= '0;
                r_tsq      <= '0;
                r_tv       <= '0;
                r_num      <= '0;
                r_bsq      <= '0;
                r_bcnt     <= '0;
            end
            ST_RUN: begin
                r_j   <= r_j + 1'b1;
                r_idx <= ({1'b0, r_idx} == r_len - 1'b1) ? '0 : r_idx + 1'b1;
                r_bpos <= ({1'b0, r_bpos} == bs_m1) ? '0 : r_bpos + 1'b1;
            end
            ST_DRAIN: begin
                r_work <= r_num;
                r_drem <= '0;
                r_cnt  <= '0;
                if (!cfg.use_confidence) r_score <= SCORE_W'(r_tsq);
                else r_score <= SCORE_INF;
            end
            ST_DIV: begin
                r_work <= quo_nxt;
                r_drem <= div_ge ? LEN_W'(div_t - {1'b0, r_tv}) : div_t[LEN_W-1:0];
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == 6'(DIV_STEPS - 1)) r_score <= quo_nxt;
            end
            ST_CMP: begin
                if (better) begin
                    r_best     <= r_score;
                    r_best_idx <= r_s;
                    r_best_vc  <= cfg.use_confidence ? r_tv : '0;
                end
                r_work <= better ? r_score : r_best;
                r_srem <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_s    <= r_s + 1'b1;
                r_base <= base_nxt[ADDR_W-1:0];
                r_j    <= '0;
                r_idx  <= base_nxt[ADDR_W-1:0];
                r_bpos <= '0;
                r_tsq  <= '0;
                r_tv   <= '0;
                r_num  <= '0;
            end
            ST_SQRT: begin
                r_work <= {r_work[SCORE_W-3:0], 2'b00};
                r_srem <= sq_ge ? (SQRT_STEPS+1)'(sq_t - sq_trial)
                                : sq_t[SQRT_STEPS:0];
                r_root <= {r_root[SQRT_STEPS-2:0], sq_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == 6'(SQRT_STEPS - 1)) begin
                    r_best <= SCORE_W'({r_root[SQRT_STEPS-2:0], sq_ge});
                end
            end
            ST_DONE: begin
                if (r_err) begin
                    o_res.status        <= STATUS_BAD_LEN;
                    o_res.best_shift    <= '0;
                    o_res.best_distance <= SCORE_INF;
                    o_res.valid_count   <= '0;
                end else if (r_best == SCORE_INF) begin
                    o_res.status        <= STATUS_NO_VALID;
                    o_res.best_shift    <= '0;
                    o_res.best_distance <= SCORE_INF;
                    o_res.valid_count   <= '0;
                end else begin
                    o_res.status        <= STATUS_OK;
                    o_res.best_shift    <= r_best_idx;
                    o_res.best_distance <= r_best;
                    o_res.valid_count   <= r_best_vc;
                end
            end
            default: ;
        endcase
    end

endmodule
